// File: rtl/mcdc_pkg.sv
// Shared constants, code table, queue entry type and lookup functions for the Morse codec.
package mcdc_pkg;

  localparam int MAX_SYMBOLS = 5;
  localparam int LEN_W       = $clog2(MAX_SYMBOLS + 1);
  localparam int CODE_W      = 5;
  localparam int CLEN_W      = 3;
  localparam int NCODES      = 36;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int STEP_W      = 3;

  localparam logic [7:0] DOT_CH  = 8'h2B;
  localparam logic [7:0] DASH_CH = 8'h3D;
  localparam logic [7:0] BAR_CH  = 8'h7C;
  localparam logic [7:0] SPC_CH  = 8'h20;
  localparam logic [7:0] NL_CH   = 8'h0A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [7:0] CODE_CH [NCODES] = '{
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
    8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52,
    8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39
  };

  localparam logic [CLEN_W-1:0] CODE_LEN [NCODES] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3,
    3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam logic [CODE_W-1:0] CODE_BITS [NCODES] = '{
    5'd1, 5'd8, 5'd10, 5'd4, 5'd0, 5'd2, 5'd6, 5'd0, 5'd0,
    5'd7, 5'd5, 5'd4, 5'd3, 5'd2, 5'd7, 5'd6, 5'd13, 5'd2,
    5'd0, 5'd1, 5'd1, 5'd1, 5'd3, 5'd9, 5'd11, 5'd12,
    5'd31, 5'd15, 5'd7, 5'd3, 5'd1, 5'd0, 5'd16, 5'd24, 5'd28, 5'd30
  };

  // One queue entry: the results of one item, emitted in field order.
  typedef struct packed {
    logic              pre_sp;
    logic [CLEN_W-1:0] sym_len;
    logic [CODE_W-1:0] sym_bits;
    logic              chr_vld;
    logic [7:0]        chr;
    logic              err;
    logic              post_sp;
  } desc_t;

  typedef struct packed {
    logic              hit;
    logic [CLEN_W-1:0] len;
    logic [CODE_W-1:0] bits;
  } enc_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] chr;
  } dec_t;

  function automatic enc_t enc_lookup(input logic [7:0] ch);
    enc_t r;
    r = '0;
    for (int i = 0; i < NCODES; i++) begin
      if (CODE_CH[i] == ch) begin
        r.hit  = 1'b1;
        r.len  = CODE_LEN[i];
        r.bits = CODE_BITS[i];
      end
    end
    return r;
  endfunction

  function automatic dec_t dec_lookup(input logic [LEN_W-1:0] len,
                                      input logic [MAX_SYMBOLS-1:0] bits);
    dec_t r;
    r = '0;
    for (int i = 0; i < NCODES; i++) begin
      if (LEN_W'(CODE_LEN[i]) == len && MAX_SYMBOLS'(CODE_BITS[i]) == bits) begin
        r.hit = 1'b1;
        r.chr = CODE_CH[i];
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/mcdc_front.sv
// Front end: accepts stream bytes, tracks token and spacing state, queues result descriptors.
module mcdc_front import mcdc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       mode,
  input  logic       acc,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  output logic       q_push,
  output desc_t      q_wdata
);

  logic                   first_r, first_nxt;
  logic [MAX_SYMBOLS-1:0] tok_bits_r, tok_bits_nxt;
  logic [LEN_W-1:0]       tok_len_r, tok_len_nxt;
  logic                   tok_long_r, tok_long_nxt;
  logic                   halted_r, halted_nxt;

  logic       enq;
  desc_t      desc;
  logic [7:0] ub;
  enc_t       enc;
  dec_t       dec;
  logic       is_sym;
  logic       closing;
  logic       bar;

  always_comb begin
    ub = in_byte;
    if (in_byte inside {[8'h61:8'h7A]}) ub = in_byte - CASE_OFS;
    enc     = enc_lookup(ub);
    dec     = dec_lookup(tok_len_r, tok_bits_r);
    is_sym  = !in_end_of_input && (in_byte == DOT_CH || in_byte == DASH_CH);
    closing = (tok_len_r != '0) || tok_long_r;
    bar     = !in_end_of_input && (in_byte == BAR_CH);

    enq          = 1'b0;
    desc         = '0;
    first_nxt    = first_r;
    tok_bits_nxt = tok_bits_r;
    tok_len_nxt  = tok_len_r;
    tok_long_nxt = tok_long_r;
    halted_nxt   = halted_r;

    if (!halted_r) begin
      if (!mode) begin
        if (!in_end_of_input) begin
          if (in_byte == SPC_CH) begin
            desc.chr_vld = 1'b1;
            desc.chr     = BAR_CH;
            enq          = 1'b1;
            first_nxt    = 1'b1;
          end else if (in_byte != NL_CH && enc.hit) begin
            desc.pre_sp   = !first_r;
            desc.sym_len  = enc.len;
            desc.sym_bits = enc.bits;
            enq           = 1'b1;
            first_nxt     = 1'b0;
          end
        end
      end else if (is_sym) begin
        if (tok_len_r >= LEN_W'(MAX_SYMBOLS)) begin
          tok_long_nxt = 1'b1;
        end else begin
          tok_bits_nxt = {tok_bits_r[MAX_SYMBOLS-2:0], in_byte == DASH_CH};
          tok_len_nxt  = tok_len_r + 1'b1;
        end
      end else begin
        tok_bits_nxt = '0;
        tok_len_nxt  = '0;
        tok_long_nxt = 1'b0;
        if (closing && (tok_long_r || !dec.hit)) begin
          desc.err   = 1'b1;
          enq        = 1'b1;
          halted_nxt = 1'b1;
        end else begin
          desc.chr_vld = closing;
          desc.chr     = dec.chr;
          desc.post_sp = bar;
          enq          = closing || bar;
        end
      end
    end
  end

  assign q_push  = acc && enq;
  assign q_wdata = desc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r    <= 1'b1;
      tok_bits_r <= '0;
      tok_len_r  <= '0;
      tok_long_r <= 1'b0;
      halted_r   <= 1'b0;
    end else if (acc) begin
      first_r    <= first_nxt;
      tok_bits_r <= tok_bits_nxt;
      tok_len_r  <= tok_len_nxt;
      tok_long_r <= tok_long_nxt;
      halted_r   <= halted_nxt;
    end
  end

endmodule

// File: rtl/mcdc_queue.sv
// Short descriptor queue between front and back ends.
module mcdc_queue import mcdc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t wdata,
  output logic  full,
  input  logic  pop,
  output desc_t rdata,
  output logic  empty
);

  desc_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/mcdc_back.sv
// Back end: expands the head descriptor into result bytes in the output register, one per cycle while not stalled.
module mcdc_back import mcdc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  desc_t      q_head,
  output logic       q_pop,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_byte,
  output logic       out_error,
  output logic       out_last
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              vld_r;
  logic [7:0]        byte_r;
  logic              err_r;
  logic              last_r;

  logic              load;
  logic [STEP_W-1:0] n_elems;
  logic [STEP_W-1:0] rel;
  logic [STEP_W-1:0] tail;
  logic [STEP_W-1:0] sym_idx;
  logic              el_last;
  logic [7:0]        el_byte;
  logic              el_err;

  always_comb begin
    n_elems = STEP_W'(q_head.pre_sp) + STEP_W'(q_head.sym_len) + STEP_W'(q_head.chr_vld)
            + STEP_W'(q_head.err) + STEP_W'(q_head.post_sp);
    rel     = step_r - STEP_W'(q_head.pre_sp);
    tail    = rel - STEP_W'(q_head.sym_len);
    sym_idx = STEP_W'(q_head.sym_len) - rel - 1'b1;
    el_last = (step_r == n_elems - 1'b1);
    el_err  = 1'b0;
    el_byte = SPC_CH;
    if (q_head.pre_sp && step_r == '0) begin
      el_byte = SPC_CH;
    end else if (rel < STEP_W'(q_head.sym_len)) begin
      el_byte = q_head.sym_bits[sym_idx] ? DASH_CH : DOT_CH;
    end else if (tail == '0 && q_head.chr_vld) begin
      el_byte = q_head.chr;
    end else if (tail == '0 && q_head.err) begin
      el_byte = '0;
      el_err  = 1'b1;
    end
    load     = !q_empty && (!vld_r || out_pop);
    step_nxt = el_last ? '0 : step_r + 1'b1;
  end

  assign q_pop     = load && el_last;
  assign out_empty = !vld_r;
  assign out_byte  = byte_r;
  assign out_error = err_r;
  assign out_last  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      if (load) begin
        step_r <= step_nxt;
        vld_r  <= 1'b1;
      end else if (out_pop) begin
        vld_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= el_byte;
      err_r  <= el_err;
      last_r <= el_last;
    end
  end

endmodule

// File: rtl/morse_stream_codec.sv
// Top level of the Morse stream codec: mode register, front end, descriptor queue, back end.
//
//  channel  | ports                                        | transaction when
//  ---------+----------------------------------------------+------------------------
//  input    | in_push, full, in_byte, in_end_of_input      | in_push & !full
//  result   | pop, empty, out_byte, out_error, out_last    | pop & !empty
//  config   | cfg_wr_en, cfg_wr_data (mode)                | cfg_wr_en
//
// The front end takes one input transaction per cycle while the 4-entry queue has room.
// The back end emits one result per cycle while results are popped; an encoded character
// yields up to six results (leading space plus five symbols), a decoded token one or two,
// so the back end sets the sustained rate; empty falls after the queue and output register.
// Synchronous active-low reset clears mode, token state, queue and output valid flag.
// A stalled result side fills the queue and then raises full; an error halts until reset.
module morse_stream_codec import mcdc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_error,
  output logic       out_last
);

  logic  mode_r;
  logic  acc;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  desc_t q_wdata;
  desc_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  assign full = q_full;
  assign acc  = in_push && !q_full;

  mcdc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .mode            (mode_r),
    .acc             (acc),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .q_push          (q_push),
    .q_wdata         (q_wdata)
  );

  mcdc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  mcdc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (pop),
    .out_empty (empty),
    .out_byte  (out_byte),
    .out_error (out_error),
    .out_last  (out_last)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push) else $error("queue written while full");

  a_pop_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (!empty && out_last)) else $error("descriptor retired without last result");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_error) |-> (out_last && out_byte == 8'h00))
    else $error("error result malformed");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue read while empty");

endmodule

// File: tb/sv/morse_stream_codec_tb.sv
// Self-checking testbench for morse_stream_codec: directed and random streams, both modes.
`timescale 1ns / 100ps

module morse_stream_codec_tb import mcdc_pkg::*;;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;
  localparam int   SETTLE_CYC  = 20;

  typedef struct {
    logic [7:0] ch;
    logic       err;
    logic       last;
  } emit_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_input = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_error;
  logic       out_last;

  int send_gap_pct = 0;
  int pop_stall_pct = 0;
  int mismatches = 0;

  // predicted codec state
  logic  mode_q = MODE_ENCODE;
  logic  first_code_q = 1'b1;
  string token_q = "";
  logic  token_ovf_q = 1'b0;
  logic  halted_q = 1'b0;

  emit_t pending_emits[$];

  string glyph_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
  string morse_codes [36] = '{
    "+=", "=+++", "=+=+", "=++", "+", "++=+", "==+", "++++", "++", "+===",
    "=+=", "+=++", "==", "=+", "===", "+==+", "==+=", "+=+", "+++", "=",
    "++=", "+++=", "+==", "=++=", "=+==", "==++",
    "=====", "+====", "++===", "+++==", "++++=", "+++++", "=++++", "==+++",
    "===++", "====+"
  };

  morse_stream_codec i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_push         (in_push),
    .full            (full),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_error       (out_error),
    .out_last        (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("morse_stream_codec_tb: FAIL");
    $finish;
  end

  function automatic string code_of(input logic [7:0] c);
    for (int i = 0; i < 36; i++) begin
      if (glyph_set[i] == c) return morse_codes[i];
    end
    return "";
  endfunction

  function automatic logic [8:0] char_of(input string t);
    for (int i = 0; i < 36; i++) begin
      if (morse_codes[i] == t) return {1'b1, glyph_set[i]};
    end
    return 9'h000;
  endfunction

  task automatic predict_emits(input logic [7:0] b, input logic eoi);
    emit_t      q[$];
    logic [7:0] c;
    string      pat;
    logic [8:0] hit;
    logic       bad;
    bad = 1'b0;
    if (halted_q) return;
    if (mode_q == MODE_ENCODE) begin
      if (!eoi && b != NL_CH) begin
        if (b == SPC_CH) begin
          q.push_back('{BAR_CH, 1'b0, 1'b0});
          first_code_q = 1'b1;
        end else begin
          c = (b >= "a" && b <= "z") ? b - CASE_OFS : b;
          pat = code_of(c);
          if (pat.len() != 0) begin
            if (!first_code_q) q.push_back('{SPC_CH, 1'b0, 1'b0});
            for (int i = 0; i < pat.len(); i++) begin
              q.push_back('{pat[i], 1'b0, 1'b0});
            end
            first_code_q = 1'b0;
          end
        end
      end
    end else if (!eoi && (b == DOT_CH || b == DASH_CH)) begin
      if (token_q.len() >= MAX_SYMBOLS) begin
        token_ovf_q = 1'b1;
      end else if (b == DASH_CH) begin
        token_q = {token_q, "="};
      end else begin
        token_q = {token_q, "+"};
      end
    end else begin
      if (token_ovf_q) begin
        bad = 1'b1;
      end else if (token_q.len() != 0) begin
        hit = char_of(token_q);
        if (hit[8]) q.push_back('{hit[7:0], 1'b0, 1'b0});
        else bad = 1'b1;
      end
      token_q = "";
      token_ovf_q = 1'b0;
      if (bad) begin
        q.push_back('{8'h00, 1'b1, 1'b0});
        halted_q = 1'b1;
      end else if (!eoi && b == BAR_CH) begin
        q.push_back('{SPC_CH, 1'b0, 1'b0});
      end
    end
    if (q.size() > 0) q[q.size()-1].last = 1'b1;
    foreach (q[i]) pending_emits.push_back(q[i]);
  endtask

  // one input transaction, with optional idle cycles ahead of it
  task automatic push_item(input logic [7:0] b, input logic eoi);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_byte <= b;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_emits(b, eoi);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
  endtask

  task automatic settle_codec();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_emits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    settle_codec();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    mode_q = m;
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    pop <= ($urandom_range(0, 99) >= pop_stall_pct);
  end

  always @(posedge clk) begin
    emit_t e;
    if (rst_n && pop && !empty) begin
      if (pending_emits.size() == 0) begin
        $display("%0t: unexpected result exp none got byte %h error %b last %b",
                 $time, out_byte, out_error, out_last);
        mismatches++;
      end else begin
        e = pending_emits.pop_front();
        if (out_byte !== e.ch) begin
          $display("%0t: out_byte exp %h got %h", $time, e.ch, out_byte);
          mismatches++;
        end
        if (out_error !== e.err) begin
          $display("%0t: out_error exp %b got %b", $time, e.err, out_error);
          mismatches++;
        end
        if (out_last !== e.last) begin
          $display("%0t: out_last exp %b got %b", $time, e.last, out_last);
          mismatches++;
        end
      end
    end
  end

  task automatic test_encode_directed();
    push_text("Ab\n 09Zz");
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h7E, 1'b0);
    push_item("5", 1'b0);
    push_item("Q", 1'b1);
    push_item(8'hE5, 1'b0);
  endtask

  task automatic test_decode_directed();
    write_mode(MODE_DECODE);
    push_text("+=|=====");
    push_item(8'h00, 1'b1);
    push_text("+++++");
    push_item(8'h80, 1'b0);
    push_text("||");
    push_item(8'hFF, 1'b1);
    push_text("=");
    push_item(8'hFF, 1'b0);
    push_text("+");
    push_item(BAR_CH, 1'b1);
  endtask

  task automatic test_mode_switch();
    push_text("++");
    write_mode(MODE_ENCODE);
    push_text("e t");
    write_mode(MODE_DECODE);
    push_text("=|");
  endtask

  task automatic random_encode(input int n);
    logic [7:0] b;
    int         r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        b = glyph_set[$urandom_range(0, 35)];
        if (b >= "A" && $urandom_range(0, 1)) b = b + CASE_OFS;
      end else if (r < 75) begin
        b = SPC_CH;
      end else if (r < 80) begin
        b = NL_CH;
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      push_item(b, ($urandom_range(0, 19) == 0));
    end
  endtask

  task automatic random_decode(input int n);
    logic [7:0] b;
    string      pat;
    int         r;
    int         k;
    k = 0;
    while (k < n) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        pat = morse_codes[$urandom_range(0, 35)];
        for (int i = 0; i < pat.len(); i++) push_item(pat[i], 1'b0);
        k += pat.len();
      end
      r = $urandom_range(0, 99);
      do b = 8'($urandom_range(0, 255)); while (b == DOT_CH || b == DASH_CH);
      if (r < 40) push_item(BAR_CH, 1'b0);
      else if (r < 55) push_item(b, 1'b1);
      else push_item(b, 1'b0);
      k++;
    end
  endtask

  task automatic test_random_traffic();
    int gaps [4] = '{0, 86, 0, 27};
    int stalls [4] = '{0, 0, 86, 27};
    for (int p = 0; p < 4; p++) begin
      send_gap_pct = gaps[p];
      pop_stall_pct = stalls[p];
      write_mode(MODE_ENCODE);
      random_encode(14);
      write_mode(MODE_DECODE);
      random_decode(14);
    end
    send_gap_pct = 0;
    pop_stall_pct = 0;
  endtask

  // overlong token: error result, no trailing space, then nothing until reset
  task automatic test_error_halt();
    write_mode(MODE_DECODE);
    push_text("==+==+|");
    push_text("+=|");
    push_item(8'h00, 1'b1);
    write_mode(MODE_ENCODE);
    push_text("A 1");
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_encode_directed();
    test_decode_directed();
    test_mode_switch();
    test_random_traffic();
    test_error_halt();
    settle_codec();
    if (mismatches == 0) begin
      $display("morse_stream_codec_tb: PASS");
    end else begin
      $display("morse_stream_codec_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mcdc_pkg.sv
rtl/mcdc_front.sv
rtl/mcdc_queue.sv
rtl/mcdc_back.sv
rtl/morse_stream_codec.sv
tb/sv/morse_stream_codec_tb.sv
